@@ design/mef_pkg.sv @@
// ----------------------------------------------------------------------------
// mef_pkg
// Shared sizes, types and state codes of the majority element finder.
// ----------------------------------------------------------------------------
package mef_pkg;

   // Buffer capacity and value width
   localparam int MAX_ITEMS   = 1024;
   localparam int VALUE_WIDTH = 32;

   // Address into the buffer, and a count that can hold the capacity itself
   localparam int ADDR_WIDTH  = $clog2(MAX_ITEMS);
   localparam int COUNT_WIDTH = $clog2(MAX_ITEMS + 1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [ADDR_WIDTH-1:0]         addr_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_LOAD  = 3'b001,
      ST_VOTE  = 3'b010,
      ST_COUNT = 3'b100
   } state_type;

endpackage

@@ design/mef_ram.sv @@
// ----------------------------------------------------------------------------
// mef_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mef_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/majority_element_finder.sv @@
// Operation: a loading transfer stores its item; the closing transfer starts a vote
// pass and then a count pass over the n stored values, and the result is registered
// at the end of the count pass.
// Throughput: one item per cycle while loading; no item is taken during the passes,
// and the closing item waits while a result is still held.
// Reset: synchronous; clears sequencer, item count, overflow flag, read valid and result valid, not the buffer.
// ----------------------------------------------------------------------------
// majority_element_finder
// Buffers a set of values, then finds the value held by more than half of the
// set with a vote pass and a confirming count pass over the buffer.
// ----------------------------------------------------------------------------
module majority_element_finder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mef_pkg::value_type req_item_value,
   input  logic               req_last_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_found,
   output mef_pkg::value_type rsp_majority_value,
   output logic               rsp_overflow
);
   import mef_pkg::*;

   state_type state_ff, state_in;
   count_type item_count_ff, item_count_in;
   logic      overflow_seen_ff, overflow_seen_in;
   count_type eval_n_ff, eval_n_in;
   logic      eval_ovf_ff, eval_ovf_in;
   count_type idx_ff, idx_in;
   logic      rd_valid_ff, rd_valid_in;
   value_type cand_ff, cand_in;
   count_type votes_ff, votes_in;
   count_type hits_ff, hits_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff, rsp_found_in;
   value_type rsp_value_ff, rsp_value_in;
   logic      rsp_ovf_ff, rsp_ovf_in;

   logic      req_xfer;
   logic      rsp_xfer;
   logic      store;
   logic      issue;
   logic      pass_done;
   value_type rd_data;

   // Hold off the closing item while a result still waits; no loading during passes
   assign req_stall = (state_ff != ST_LOAD) || (rsp_valid_ff && req_last_item);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign store     = req_xfer && (item_count_ff < count_type'(MAX_ITEMS));

   // Read issue and end of a pass
   assign issue     = (state_ff != ST_LOAD) && (idx_ff < eval_n_ff);
   assign pass_done = (state_ff != ST_LOAD) && (idx_ff == eval_n_ff) && !rd_valid_ff;

   mef_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (item_count_ff[ADDR_WIDTH-1:0]),
      .wr_data (req_item_value),
      .rd_en   (issue),
      .rd_addr (idx_ff[ADDR_WIDTH-1:0]),
      .rd_data (rd_data)
   );

   // Sequencer, counters and vote datapath
   always_comb begin
      state_in         = state_ff;
      item_count_in    = item_count_ff;
      overflow_seen_in = overflow_seen_ff;
      eval_n_in        = eval_n_ff;
      eval_ovf_in      = eval_ovf_ff;
      idx_in           = idx_ff;
      rd_valid_in      = issue;
      cand_in          = cand_ff;
      votes_in         = votes_ff;
      hits_in          = hits_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_xfer;
      rsp_found_in     = rsp_found_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_ovf_in       = rsp_ovf_ff;

      if (issue) begin
         idx_in = idx_ff + count_type'(1);
      end

      unique case (state_ff)
         ST_LOAD: begin
            // Store or drop, close the set on the last item
            if (req_xfer) begin
               if (store) begin
                  item_count_in = item_count_ff + count_type'(1);
               end else begin
                  overflow_seen_in = 1'b1;
               end
               if (req_last_item) begin
                  eval_n_in        = store ? item_count_ff + count_type'(1) : item_count_ff;
                  eval_ovf_in      = overflow_seen_ff || !store;
                  item_count_in    = '0;
                  overflow_seen_in = 1'b0;
                  idx_in           = '0;
                  votes_in         = '0;
                  cand_in          = '0;
                  state_in         = ST_VOTE;
               end
            end
         end
         ST_VOTE: begin
            // Pair off differing values; the survivor is the candidate
            if (rd_valid_ff) begin
               if (votes_ff == '0) begin
                  cand_in  = rd_data;
                  votes_in = count_type'(1);
               end else if (rd_data == cand_ff) begin
                  votes_in = votes_ff + count_type'(1);
               end else begin
                  votes_in = votes_ff - count_type'(1);
               end
            end
            if (pass_done) begin
               idx_in   = '0;
               hits_in  = '0;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            // Confirm the candidate by counting its occurrences
            if (rd_valid_ff && (rd_data == cand_ff)) begin
               hits_in = hits_ff + count_type'(1);
            end
            if (pass_done) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = (eval_n_ff != '0) && (hits_ff > (eval_n_ff >> 1));
               rsp_value_in = rsp_found_in ? cand_ff : '0;
               rsp_ovf_in   = eval_ovf_ff;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_LOAD;
         item_count_ff    <= '0;
         overflow_seen_ff <= 1'b0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         item_count_ff    <= item_count_in;
         overflow_seen_ff <= overflow_seen_in;
         rd_valid_ff      <= rd_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      eval_n_ff    <= eval_n_in;
      eval_ovf_ff  <= eval_ovf_in;
      idx_ff       <= idx_in;
      cand_ff      <= cand_in;
      votes_ff     <= votes_in;
      hits_ff      <= hits_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_majority_value = rsp_value_ff;
   assign rsp_overflow       = rsp_ovf_ff;

`ifndef SYNTH
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> state_ff == ST_LOAD)
      else $error("item transfer outside loading");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      item_count_ff <= count_type'(MAX_ITEMS))
      else $error("item count beyond capacity");
   a_rsp_from_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_COUNT)
      else $error("result raised outside count pass");
   a_no_read_in_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !issue)
      else $error("buffer read during loading");
   a_zero_when_absent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> rsp_value_ff == '0)
      else $error("value given without majority");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Feeds data sets to the majority element finder through the request channel
// and checks every result against a tally of the values that were stored.
// Covers single-item sets, ties, extreme values, a full buffer and overflow,
// then random sets under bursty sending and a patterned result stall.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mef_pkg::*;

   localparam int RANDOM_ITEMS = 250;
   localparam int IDLE_LIMIT   = 10000;
   localparam int DRAIN_CYCLES = 200;

   localparam value_type VALUE_MIN = 32'sh8000_0000;
   localparam value_type VALUE_MAX = 32'sh7fff_ffff;
   localparam value_type MINUS_ONE = -32'sd1;

   typedef struct {
      bit        found;
      value_type majority_value;
      bit        overflow;
   } verdict_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      req_valid      = 1'b0;
   logic      req_stall;
   value_type req_item_value = '0;
   logic      req_last_item  = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall      = 1'b0;
   logic      rsp_found;
   value_type rsp_majority_value;
   logic      rsp_overflow;

   // Values of the set under construction, the set the block is holding,
   // and the verdicts still owed by the block
   value_type      set_values[$];
   value_type      loaded_values[$];
   bit             set_overflowed = 1'b0;
   verdict_type    pending_verdicts[$];

   int             error_count      = 0;
   int             items_accepted   = 0;
   int             sets_closed      = 0;
   int             results_seen     = 0;
   int             majorities_found = 0;
   int             overflow_results = 0;
   int             idle_cycles      = 0;
   int             burst_left       = 0;
   int             stall_tick       = 0;
   stall_mode_type stall_mode       = STALL_NONE;

   majority_element_finder DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_item_value     (req_item_value),
      .req_last_item      (req_last_item),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_majority_value (rsp_majority_value),
      .rsp_overflow       (rsp_overflow)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Count occurrences of each held value and pick one above half the count
   function automatic verdict_type tally_majority();
      int          tally [bit [31:0]];
      verdict_type v;
      bit [31:0]   key;
      v.found          = 1'b0;
      v.majority_value = '0;
      v.overflow       = 1'b0;
      foreach (loaded_values[i]) tally[loaded_values[i]]++;
      if (tally.first(key)) begin
         do begin
            if (tally[key] > loaded_values.size() / 2) begin
               v.found          = 1'b1;
               v.majority_value = key;
            end
         end while (tally.next(key));
      end
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("MISMATCH result %0d: %s expected %h got %h", results_seen, what, want, got);
      error_count++;
   endtask

   // Capture each request transfer and predict the verdict on the closing item
   always @(posedge clock) begin : capture_request
      verdict_type v;
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         items_accepted++;
         if (loaded_values.size() < MAX_ITEMS) loaded_values.push_back(req_item_value);
         else set_overflowed = 1'b1;
         if (req_last_item) begin
            v          = tally_majority();
            v.overflow = set_overflowed;
            pending_verdicts.push_back(v);
            loaded_values.delete();
            set_overflowed = 1'b0;
            sets_closed++;
         end
      end
   end

   // Compare each result transfer with the oldest owed verdict
   always @(posedge clock) begin : check_result
      verdict_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("result with no set closed", '0, rsp_majority_value);
         end else begin
            want = pending_verdicts.pop_front();
            if (want.found) majorities_found++;
            if (want.overflow) overflow_results++;
            if (rsp_found !== want.found)
               report_mismatch("found", want.found, rsp_found);
            if (rsp_majority_value !== want.majority_value)
               report_mismatch("majority_value", want.majority_value, rsp_majority_value);
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", want.overflow, rsp_overflow);
         end
      end
   end

   // Stall the result channel on a randomly chosen pattern: none, light, heavy or periodic
   always @(posedge clock) begin : drive_rsp_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick++;
         if (stall_tick % 256 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
            default:     rsp_stall <= ((stall_tick % 7) < 3);
         endcase
      end
   end

   // Stop the run when nothing moves on either channel for too long
   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
               $display("== FAIL ==");
               $finish;
            end
         end
      end
   end

   // Present one item, hold it until transferred, then maybe pause the burst
   task automatic send_item(input value_type value, input logic last);
      int gap;
      req_valid      <= 1'b1;
      req_item_value <= value;
      req_last_item  <= last;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
         burst_left--;
      end
      if (gap > 0) begin
         req_valid      <= 1'b0;
         req_item_value <= $urandom;
         req_last_item  <= $urandom_range(0, 1);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_set();
      foreach (set_values[i]) send_item(set_values[i], i == set_values.size() - 1);
      set_values.delete();
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(0, 15))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return MINUS_ONE;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic void shuffle_set();
      int        j;
      value_type t;
      for (int i = set_values.size() - 1; i > 0; i--) begin
         j             = $urandom_range(0, i);
         t             = set_values[i];
         set_values[i] = set_values[j];
         set_values[j] = t;
      end
   endfunction

   task automatic test_directed();
      // Single items: zero, the most negative value and minus one
      set_values = '{32'sd0};                             send_set();
      set_values = '{VALUE_MIN};                          send_set();
      set_values = '{MINUS_ONE};                          send_set();
      // Most positive value wins
      set_values = '{VALUE_MAX, VALUE_MAX, MINUS_ONE};    send_set();
      // Minus one as a genuine majority
      set_values = '{MINUS_ONE, MINUS_ONE, MINUS_ONE, 32'sd5}; send_set();
      // Exactly half is not a majority; then a two-of-three majority and a set with none
      set_values = '{32'sd1, 32'sd2};                     send_set();
      set_values = '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555};
      send_set();
      set_values = '{VALUE_MIN, 32'sd7, VALUE_MIN};       send_set();
      set_values = '{32'sd5, 32'sd6, 32'sd7};             send_set();
   endtask

   task automatic test_overflow();
      value_type dom;
      value_type rival;
      // Bare majority in a full buffer; the dropped rivals, the last one
      // included, would sink it if they were counted
      dom   = $urandom;
      rival = ~dom;
      for (int i = 0; i < MAX_ITEMS; i++)
         set_values.push_back(i < MAX_ITEMS / 2 + 1 ? dom : value_type'($urandom));
      shuffle_set();
      for (int i = 0; i < 10; i++) set_values.push_back(rival);
      send_set();
   endtask

   task automatic test_random_sets();
      int        sent;
      int        n;
      int        k;
      int        kind;
      value_type dom;
      value_type pool[4];
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         n    = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
         kind = $urandom_range(0, 9);
         dom  = pick_value();
         foreach (pool[i]) pool[i] = pick_value();
         if (kind < 6) begin
            // Clear majority with a few rival values
            k = $urandom_range(n / 2 + 1, n);
            for (int i = 0; i < n; i++)
               set_values.push_back(i < k ? dom : pool[$urandom_range(0, 2)]);
         end else if (kind < 8) begin
            // Tie at exactly half
            if (n % 2) n++;
            for (int i = 0; i < n; i++)
               set_values.push_back(i < n / 2 ? dom : value_type'($urandom));
         end else begin
            // Noise from a small pool or fully random
            for (int i = 0; i < n; i++)
               set_values.push_back(kind == 8 ? pool[$urandom_range(0, 3)]
                                              : value_type'($urandom));
         end
         if ($urandom_range(0, 3) != 0) shuffle_set();
         sent += n;
         send_set();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_overflow();
      test_random_sets();
      req_valid <= 1'b0;

      // Drain owed results, then watch for strays
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items in %0d sets; %0d results checked", items_accepted, sets_closed,
               results_seen);
      $display("%0d sets had a majority, %0d overflowed the buffer", majorities_found,
               overflow_results);
      if (error_count == 0 && pending_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/mef_pkg.sv
design/mef_ram.sv
design/majority_element_finder.sv
tb/testbench.sv
